// ----- rtl/core/ascii_decimal_number_parser_macros.svh -----
// Assertion macros for the ASCII decimal number parser.
// Standalone header; included by adnp_parse_core, which checks its own logic.
`ifndef ASCII_DECIMAL_NUMBER_PARSER_MACROS_SVH
`define ASCII_DECIMAL_NUMBER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define ADNP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("adnp assertion failed");
`define ADNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("adnp assertion failed");
`else
`define ADNP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ADNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/adnp_pkg.sv -----
// Shared types, character codes and arithmetic helpers of the decimal parser.
// No dependencies.
package adnp_pkg;

	localparam logic       OP_CHAR    = 1'b0;
	localparam logic       OP_END     = 1'b1;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] IGNORE_NONE = 8'h00;

	localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	// largest magnitude that still takes one more digit without overflow
	localparam logic [63:0] LIMIT_LOW_DIGIT  = 64'd922337203685477580;
	localparam logic [63:0] LIMIT_HIGH_DIGIT = 64'd922337203685477579;
	localparam logic [4:0]  FRAC_MAX  = 5'd31;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
		logic       decimal_mode;
	} item_t;

	typedef struct packed {
		logic               consumed;
		logic               done_res;
		logic               parse_error;
		logic signed [63:0] mantissa;
		logic [4:0]         fraction_digits;
	} res_t;

	function automatic logic [63:0] times_ten_plus(input logic [63:0] x, input logic [3:0] d);
		return (x << 3) + (x << 1) + {60'd0, d};
	endfunction

	function automatic logic [63:0] digit_limit(input logic [3:0] d);
		return (d >= 4'd8) ? LIMIT_HIGH_DIGIT : LIMIT_LOW_DIGIT;
	endfunction

endpackage

// ----- rtl/core/adnp_in_if.sv -----
// Character input channel: valid/ready with one character beat.
// No dependencies.
interface adnp_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] char_code;
	logic       decimal_mode;

	modport source (output valid, operation, char_code, decimal_mode, input ready);
	modport sink (input valid, operation, char_code, decimal_mode, output ready);
endinterface

// ----- rtl/core/adnp_out_if.sv -----
// Result output channel: valid/ready with one result beat.
// No dependencies.
interface adnp_out_if;
	logic               valid;
	logic               ready;
	logic               consumed;
	logic               done_res;
	logic               parse_error;
	logic signed [63:0] mantissa;
	logic [4:0]         fraction_digits;

	modport source (output valid, consumed, done_res, parse_error, mantissa, fraction_digits,
		input ready);
	modport sink (input valid, consumed, done_res, parse_error, mantissa, fraction_digits,
		output ready);
endinterface

// ----- rtl/core/adnp_cfg_if.sv -----
// Configuration write channel: valid/ready with the ignore character as data.
// No dependencies.
interface adnp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/ascii_decimal_number_parser.sv -----
// ASCII decimal number parser, top level: ignore-character register and datapath.
// Path: an accepted character beat passes the input register, then the result register.
// Throughput: one character per cycle while the result channel is ready; the single-pass digit update sets this.
// Reset (arst_n low, asynchronous): parser idle, ignore character cleared to none.
// Depends on adnp_pkg, the channel interfaces, adnp_in_reg and adnp_parse_core.
module ascii_decimal_number_parser (
	input  logic        clk,
	input  logic        arst_n,
	adnp_cfg_if.sink    cfg,
	adnp_in_if.sink     chars,
	adnp_out_if.source  results
);
	import adnp_pkg::*;

	logic [7:0] ignore_q;
	logic       valid_s1;
	logic       adv;
	item_t      item_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q <= IGNORE_NONE;
		end else if (cfg.valid) begin
			ignore_q <= cfg.data;
		end
	end

	adnp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	adnp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ignore_char (ignore_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.adv         (adv),
		.results     (results)
	);
endmodule

// ----- rtl/core/adnp_in_reg.sv -----
// Input register stage: captures one character beat per cycle unless the held beat is stalled by the core.
// Depends on adnp_pkg and adnp_in_if.
module adnp_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	adnp_in_if.sink         chars,
	input  logic            adv,
	output logic            valid_s1,
	output adnp_pkg::item_t item_s1
);
	import adnp_pkg::*;

	logic take;

	assign chars.ready = !valid_s1 || adv;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{operation: chars.operation, char_code: chars.char_code,
				decimal_mode: chars.decimal_mode};
		end
	end
endmodule

// ----- rtl/core/adnp_parse_core.sv -----
// Parse state, single-pass character update and result register.
// Depends on adnp_pkg, adnp_out_if and the assertion macro header.
`include "ascii_decimal_number_parser_macros.svh"

module adnp_parse_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      ignore_char,
	input  logic            valid_s1,
	input  adnp_pkg::item_t item_s1,
	output logic            adv,
	adnp_out_if.source      results
);
	import adnp_pkg::*;

	logic        busy_q;
	logic        negative_q;
	logic        first_symbol_q;
	logic        point_seen_q;
	logic        any_consumed_q;
	logic        mode_q;
	logic [7:0]  last_char_q;
	logic [63:0] acc_q;
	logic [4:0]  digit_count_q;

	logic        res_valid_s2;
	res_t        res_s2;

	logic        neg_e, first_e, point_e, any_e, mode_e;
	logic [7:0]  last_e;
	logic [63:0] acc_e;
	logic [4:0]  dc_e;

	logic        neg_n, first_n, point_n;
	logic [63:0] acc_n;
	logic [4:0]  dc_n;
	logic        take, finish_now, ok;
	logic [7:0]  c, last_look;
	logic [3:0]  d;
	logic        is_digit, is_ign, is_end;
	logic [63:0] acc_ten, int_ten, neg_mag;
	logic [31:0] int_val;
	res_t        res_n;

	assign adv = !res_valid_s2 || results.ready;

	always_comb begin
		if (busy_q) begin
			neg_e   = negative_q;
			first_e = first_symbol_q;
			point_e = point_seen_q;
			any_e   = any_consumed_q;
			mode_e  = mode_q;
			last_e  = last_char_q;
			acc_e   = acc_q;
			dc_e    = digit_count_q;
		end else begin
			neg_e   = 1'b0;
			first_e = 1'b1;
			point_e = 1'b0;
			any_e   = 1'b0;
			mode_e  = item_s1.decimal_mode;
			last_e  = 8'h00;
			acc_e   = 64'd0;
			dc_e    = 5'd0;
		end
	end

	always_comb begin
		c        = item_s1.char_code;
		d        = c[3:0];
		is_end   = item_s1.operation == OP_END;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		is_ign   = (ignore_char != IGNORE_NONE) && (c == ignore_char);
		acc_ten  = times_ten_plus(acc_e, d);
		int_ten  = times_ten_plus({32'd0, acc_e[31:0]}, d);

		take    = 1'b0;
		neg_n   = neg_e;
		first_n = first_e;
		point_n = point_e;
		acc_n   = acc_e;
		dc_n    = dc_e;

		if (!is_end) begin
			priority if (c == CHAR_MINUS) begin
				if (first_e) begin
					neg_n = 1'b1;
					take  = 1'b1;
				end
			end else if (is_ign) begin
				take = 1'b1;
			end else if ((c == CHAR_POINT) && mode_e) begin
				if (!point_e && !first_e) begin
					point_n = 1'b1;
					take    = 1'b1;
				end
			end else if (is_digit) begin
				take    = 1'b1;
				first_n = 1'b0;
				if (!mode_e) begin
					acc_n = {32'd0, int_ten[31:0]};
				end else if (acc_e > digit_limit(d)) begin
					if (!point_e) begin
						acc_n = MAG_MAX;
					end
				end else if (point_e) begin
					if (dc_e < FRAC_MAX) begin
						dc_n  = dc_e + 5'd1;
						acc_n = acc_ten;
					end
				end else begin
					acc_n = acc_ten;
				end
			end else begin
				take = 1'b0;
			end
		end

		finish_now = is_end || !take;
		last_look  = is_end ? last_e : c;
		ok = any_e && (last_look != CHAR_MINUS) &&
			!((ignore_char != IGNORE_NONE) && (last_look == ignore_char));

		neg_mag = 64'd0 - acc_e;
		int_val = neg_e ? (32'd0 - acc_e[31:0]) : acc_e[31:0];

		res_n.consumed        = take;
		res_n.done_res        = finish_now;
		res_n.parse_error     = finish_now && !ok;
		res_n.mantissa        = 64'sd0;
		res_n.fraction_digits = 5'd0;
		if (finish_now && ok) begin
			if (mode_e) begin
				res_n.mantissa        = neg_e ? neg_mag : acc_e;
				res_n.fraction_digits = dc_e;
			end else begin
				res_n.mantissa = {{32{int_val[31]}}, int_val};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			negative_q     <= 1'b0;
			first_symbol_q <= 1'b1;
			point_seen_q   <= 1'b0;
			any_consumed_q <= 1'b0;
			mode_q         <= 1'b0;
			last_char_q    <= 8'h00;
			acc_q          <= 64'd0;
			digit_count_q  <= 5'd0;
			res_valid_s2   <= 1'b0;
		end else begin
			if (valid_s1 && adv) begin
				res_valid_s2 <= 1'b1;
				mode_q       <= mode_e;
				if (finish_now) begin
					busy_q         <= 1'b0;
					negative_q     <= 1'b0;
					first_symbol_q <= 1'b1;
					point_seen_q   <= 1'b0;
					any_consumed_q <= 1'b0;
					last_char_q    <= 8'h00;
					acc_q          <= 64'd0;
					digit_count_q  <= 5'd0;
				end else begin
					busy_q         <= 1'b1;
					negative_q     <= neg_n;
					first_symbol_q <= first_n;
					point_seen_q   <= point_n;
					any_consumed_q <= 1'b1;
					last_char_q    <= c;
					acc_q          <= acc_n;
					digit_count_q  <= dc_n;
				end
			end else if (results.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= res_n;
		end
	end

	assign results.valid           = res_valid_s2;
	assign results.consumed        = res_s2.consumed;
	assign results.done_res        = res_s2.done_res;
	assign results.parse_error     = res_s2.parse_error;
	assign results.mantissa        = res_s2.mantissa;
	assign results.fraction_digits = res_s2.fraction_digits;

	`ADNP_ASSERT_IMP(a_err_zero, clk, arst_n, res_valid_s2 && res_s2.parse_error, res_s2.mantissa == 64'sd0 && res_s2.fraction_digits == 5'd0)
	`ADNP_ASSERT_IMP(a_open_zero, clk, arst_n, res_valid_s2 && !res_s2.done_res, !res_s2.parse_error && res_s2.mantissa == 64'sd0)
	`ADNP_ASSERT_IMP(a_take_xor_done, clk, arst_n, res_valid_s2, res_s2.consumed != res_s2.done_res)
	`ADNP_ASSERT_NEXT(a_done_idle, clk, arst_n, valid_s1 && adv && finish_now, !busy_q && res_valid_s2)
	`ADNP_ASSERT_NEXT(a_take_busy, clk, arst_n, valid_s1 && adv && !finish_now, busy_q && any_consumed_q)
endmodule

// ----- tb/adnp_checker.sv -----
// Checker for the ASCII decimal number parser: watches the config, character and result
// channels, tracks the parse state itself and compares every result beat in order.
// Depends on adnp_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module adnp_checker (
	input  logic clk,
	input  logic arst_n,
	adnp_cfg_if  cfg,
	adnp_in_if   chars,
	adnp_out_if  results,
	output int   fails
);
	import adnp_pkg::*;

	logic [7:0]  ignore_chr;
	logic        busy;
	logic        neg;
	logic        at_start;
	logic        point_seen;
	logic        took_any;
	logic        dec_mode;
	logic [7:0]  last_taken;
	logic [63:0] mag;
	logic [4:0]  frac_cnt;
	res_t        pending_results[$];
	int          mismatches;

	task automatic clear_number();
		busy = 1'b0;
		neg = 1'b0;
		at_start = 1'b1;
		point_seen = 1'b0;
		took_any = 1'b0;
		last_taken = 8'h00;
		mag = 64'd0;
		frac_cnt = 5'd0;
	endtask

	task automatic push_digit(input logic [3:0] d);
		logic [31:0] w;
		if (!dec_mode) begin
			w = mag[31:0] * 32'd10 + {28'd0, d};
			mag = {32'd0, w};
		end else if (mag > (MAG_MAX - {60'd0, d}) / 64'd10) begin
			if (!point_seen)
				mag = MAG_MAX;
		end else if (!(point_seen && frac_cnt == FRAC_MAX)) begin
			if (point_seen)
				frac_cnt = frac_cnt + 5'd1;
			mag = mag * 64'd10 + {60'd0, d};
		end
	endtask

	task automatic close_number(input logic [7:0] last, inout res_t r);
		logic        ok;
		logic [31:0] w;
		ok = took_any && last != CHAR_MINUS && !(ignore_chr != IGNORE_NONE && last == ignore_chr);
		r.done_res = 1'b1;
		r.parse_error = !ok;
		r.mantissa = 64'sd0;
		r.fraction_digits = 5'd0;
		if (ok) begin
			if (dec_mode) begin
				r.mantissa = neg ? 64'd0 - mag : mag;
				r.fraction_digits = frac_cnt;
			end else begin
				w = neg ? 32'd0 - mag[31:0] : mag[31:0];
				r.mantissa = {{32{w[31]}}, w};
			end
		end
		clear_number();
	endtask

	task automatic parse_char(input item_t it, output res_t r);
		logic take;
		logic is_ign;
		if (!busy) begin
			clear_number();
			dec_mode = it.decimal_mode;
			busy = 1'b1;
		end
		r = '0;
		take = 1'b0;
		is_ign = ignore_chr != IGNORE_NONE && it.char_code == ignore_chr;
		if (it.operation == OP_END) begin
			close_number(last_taken, r);
		end else begin
			if (it.char_code == CHAR_MINUS) begin
				if (at_start) begin
					neg = 1'b1;
					take = 1'b1;
				end
			end else if (is_ign) begin
				take = 1'b1;
			end else if (it.char_code == CHAR_POINT && dec_mode) begin
				if (!point_seen && !at_start) begin
					point_seen = 1'b1;
					take = 1'b1;
				end
			end else if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
				push_digit(it.char_code[3:0]);
				at_start = 1'b0;
				take = 1'b1;
			end
			if (take) begin
				last_taken = it.char_code;
				took_any = 1'b1;
				r.consumed = 1'b1;
			end else begin
				close_number(it.char_code, r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		res_t got_r;
		if (!arst_n) begin
			ignore_chr = IGNORE_NONE;
			dec_mode = 1'b0;
			clear_number();
			pending_results.delete();
			mismatches = 0;
			fails = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				ignore_chr = cfg.data;
			if (chars.valid && chars.ready) begin
				parse_char(item_t'{chars.operation, chars.char_code, chars.decimal_mode}, exp_r);
				pending_results.push_back(exp_r);
			end
			if (results.valid && results.ready) begin
				got_r = res_t'{results.consumed, results.done_res, results.parse_error,
					results.mantissa, results.fraction_digits};
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, actual cons=%b done=%b err=%b mant=%0d frac=%0d",
						$time, got_r.consumed, got_r.done_res, got_r.parse_error,
						got_r.mantissa, got_r.fraction_digits);
				end else begin
					exp_r = pending_results.pop_front();
					if (got_r !== exp_r) begin
						mismatches++;
						$display("%0t: expected cons=%b done=%b err=%b mant=%0d frac=%0d",
							$time, exp_r.consumed, exp_r.done_res, exp_r.parse_error,
							exp_r.mantissa, exp_r.fraction_digits);
						$display("%0t: actual   cons=%b done=%b err=%b mant=%0d frac=%0d",
							$time, got_r.consumed, got_r.done_res, got_r.parse_error,
							got_r.mantissa, got_r.fraction_digits);
					end
				end
			end
			fails = mismatches + pending_results.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the parser testbench: clock, reset, directed and random character streams,
// ignore-character changes between phases and the verdict. Depends on adnp_pkg,
// the channel interfaces, the parser and adnp_checker.
`timescale 1ns / 1ps

module testbench;
	import adnp_pkg::*;

	logic clk;
	logic arst_n;
	int   sent_beats = 0;
	int   result_beats = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   fail_count;

	adnp_cfg_if cfg_ch();
	adnp_in_if  char_ch();
	adnp_out_if res_ch();

	ascii_decimal_number_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.chars(char_ch),
		.results(res_ch)
	);

	adnp_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.chars(char_ch),
		.results(res_ch),
		.fails(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
		if (res_ch.valid && res_ch.ready)
			result_beats <= result_beats + 1;
	end

	task automatic put_char(input item_t it);
		while ($urandom_range(99) < gap_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.operation <= it.operation;
		char_ch.char_code <= it.char_code;
		char_ch.decimal_mode <= it.decimal_mode;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		sent_beats++;
	endtask

	task automatic drain();
		char_ch.valid <= 1'b0;
		while (result_beats != sent_beats)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ignore(input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_number(input logic [7:0] ign);
		logic [7:0] seq[$];
		item_t      plan[$];
		logic       dm;
		logic       zero_frac;
		logic       end_after;
		int         n_minus;
		int         n_int;
		int         n_frac;
		int         r;
		dm = 1'($urandom_range(1));
		r = $urandom_range(9);
		n_minus = (r < 6) ? 0 : (r < 9) ? 1 : 2;
		r = $urandom_range(19);
		n_int = (r < 12) ? $urandom_range(1, 4) : (r < 16) ? $urandom_range(5, 10) :
			(r < 18) ? $urandom_range(11, 19) : $urandom_range(20, 26);
		n_frac = -1;
		zero_frac = ($urandom_range(3) == 0);
		if (dm && $urandom_range(2) != 0)
			n_frac = zero_frac ? $urandom_range(25, 36) : $urandom_range(0, 6);
		repeat (n_minus) seq.push_back(CHAR_MINUS);
		repeat (n_int) seq.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		if (n_frac >= 0) begin
			seq.push_back(CHAR_POINT);
			repeat (n_frac) begin
				if (zero_frac && $urandom_range(15) != 0)
					seq.push_back(CHAR_ZERO);
				else
					seq.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			end
		end
		end_after = 1'b0;
		case ($urandom_range(7))
			3, 4: seq.push_back(8'($urandom));
			5: seq.push_back(CHAR_MINUS);
			6: seq.push_back(CHAR_POINT);
			7: begin
				seq.push_back(ign);
				end_after = 1'b1;
			end
			default: end_after = 1'b1;
		endcase
		foreach (seq[i]) begin
			if (ign != IGNORE_NONE && $urandom_range(5) == 0)
				plan.push_back(item_t'{OP_CHAR, ign, 1'($urandom_range(1))});
			plan.push_back(item_t'{OP_CHAR, seq[i], 1'($urandom_range(1))});
		end
		if (end_after)
			plan.push_back(item_t'{OP_END, 8'($urandom), 1'($urandom_range(1))});
		plan[0].decimal_mode = dm;
		foreach (plan[i])
			put_char(plan[i]);
	endtask

	initial begin
		logic [7:0] ign_plan [8];
		int         phase_end;
		ign_plan = '{8'h2C, 8'hFF, 8'h2D, 8'h2E, 8'h35, 8'h20, IGNORE_NONE, 8'h00};
		ign_plan[7] = 8'($urandom_range(1, 255));
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.operation = OP_CHAR;
		char_ch.char_code = 8'h00;
		char_ch.decimal_mode = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_char(item_t'{OP_END, 8'h00, 1'b0});
		put_char(item_t'{OP_CHAR, 8'h00, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_MINUS, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_NINE, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_ZERO, 1'b0});
		put_char(item_t'{OP_CHAR, 8'hFF, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_MINUS, 1'b0});
		put_char(item_t'{OP_CHAR, 8'h61, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_MINUS, 1'b0});
		put_char(item_t'{OP_END, 8'hFF, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_ZERO + 8'd1, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_POINT, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_ZERO + 8'd5, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_POINT, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_POINT, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_MINUS, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_ZERO, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_MINUS, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_POINT, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_ZERO + 8'd7, 1'b1});
		put_char(item_t'{OP_CHAR, CHAR_POINT, 1'b0});
		put_char(item_t'{OP_CHAR, CHAR_ZERO + 8'd2, 1'b0});
		put_char(item_t'{OP_END, 8'h00, 1'b0});

		for (int p = 0; p < 8; p++) begin
			drain();
			write_ignore(ign_plan[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 65; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 65; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			phase_end = sent_beats + 225;
			while (sent_beats < phase_end) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(1, 4))
						put_char(item_t'{1'($urandom_range(3) == 0), 8'($urandom),
							1'($urandom_range(1))});
				end else begin
					send_number(ign_plan[p]);
				end
			end
			put_char(item_t'{OP_END, 8'($urandom), 1'($urandom_range(1))});
		end
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[ascii_decimal_number_parser] OK");
		else
			$display("[ascii_decimal_number_parser] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[ascii_decimal_number_parser] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/adnp_pkg.sv
rtl/core/adnp_in_if.sv
rtl/core/adnp_out_if.sv
rtl/core/adnp_cfg_if.sv
rtl/core/adnp_in_reg.sv
rtl/core/adnp_parse_core.sv
rtl/core/ascii_decimal_number_parser.sv
tb/adnp_checker.sv
tb/testbench.sv
